FILE: hdl/bavg_pkg.sv
// Package for the block average downsampler: widths, register indexes,
// the queue item type and the back-end state type. No dependencies.
package bavg_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int MAX_BLOCK = 64;
    localparam int MAX_HEIGHT = 65535;

    localparam int DEPTH_W = 16;
    localparam int ROW_W   = 16;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int BLK_W   = $clog2(MAX_BLOCK + 1);
    localparam int PH_W    = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
    localparam int SW_W    = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W   = $clog2(MAX_BLOCK * MAX_BLOCK + 1);
    localparam int SUM_W   = 28;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_ROWS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COLS = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_WIDTH  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SRC_HEIGHT = 2'd3;

    // One classified sample handed from front to back
    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic [COL_W-1:0]          col;
        logic [ROW_W-1:0]          row;
        logic                      start;
        logic                      acc;
        logic                      emit;
        logic                      last;
        logic [CNT_W-1:0]          cnt;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } t_state;

    // Back-end control strobes
    typedef struct packed {
        logic q_pop;
        logic ram_we;
        logic div_load;
        logic out_load;
    } t_back_ctl;

endpackage

FILE: hdl/bavg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bavg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/bavg_front.sv
// Front end: configuration registers, raster position counters and
// classification of each sample. Depends on bavg_pkg.
module bavg_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bavg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_push,
    input  logic signed [bavg_pkg::DEPTH_W-1:0] i_depth,
    output bavg_pkg::t_item                     o_item
);
    import bavg_pkg::*;

    logic [6:0]  r_block_rows, r_block_cols;
    logic [12:0] r_src_width;
    logic [15:0] r_src_height;

    logic [SW_W-1:0]  r_src_col, n_src_col;
    logic [ROW_W-1:0] r_src_row, n_src_row;
    logic [PH_W-1:0]  r_row_phase, n_row_phase, r_col_phase, n_col_phase;
    logic [ROW_W-1:0] r_grid_row, n_grid_row;
    logic [SW_W-1:0]  r_grid_col, n_grid_col;

    logic [SW_W-1:0]  w, bc;
    logic [ROW_W-1:0] h, br;
    logic [BLK_W-1:0] brs, bcs;
    logic             col_in, row_in;
    logic [SW_W+BLK_W:0]   col_end1, col_end2;
    logic [ROW_W+BLK_W:0]  row_end1, row_end2;
    logic [SW_W:0]    src_col_inc;
    logic [ROW_W:0]   src_row_inc;
    logic [PH_W:0]    cp_inc, rp_inc;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_rows <= 7'd4;
            r_block_cols <= 7'd4;
            r_src_width  <= 13'd4096;
            r_src_height <= 16'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_BLOCK_ROWS: r_block_rows <= i_cfg_data[6:0];
                REG_BLOCK_COLS: r_block_cols <= i_cfg_data[6:0];
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[12:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, saturate, clip block to source
    always_comb begin
        brs = (r_block_rows == '0) ? BLK_W'(1) :
              (r_block_rows > 7'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : BLK_W'(r_block_rows);
        bcs = (r_block_cols == '0) ? BLK_W'(1) :
              (r_block_cols > 7'(MAX_BLOCK)) ? BLK_W'(MAX_BLOCK) : BLK_W'(r_block_cols);
        w   = (r_src_width == '0) ? SW_W'(1) :
              (r_src_width > 13'(MAX_WIDTH)) ? SW_W'(MAX_WIDTH) : SW_W'(r_src_width);
        h   = (r_src_height == '0) ? ROW_W'(1) : r_src_height;
        br  = (ROW_W'(brs) > h) ? h : ROW_W'(brs);
        bc  = (SW_W'(bcs) > w) ? w : SW_W'(bcs);
    end

    // Grid bounds without division: g < n/b  <=>  (g+1)*b <= n
    always_comb begin
        col_end1 = (SW_W+BLK_W+1)'(r_grid_col + SW_W'(1)) * (SW_W+BLK_W+1)'(bc[BLK_W-1:0]);
        col_end2 = (SW_W+BLK_W+1)'(r_grid_col + SW_W'(2)) * (SW_W+BLK_W+1)'(bc[BLK_W-1:0]);
        row_end1 = (ROW_W+BLK_W+1)'({1'b0, r_grid_row} + 17'd1)
                   * (ROW_W+BLK_W+1)'(br[BLK_W-1:0]);
        row_end2 = (ROW_W+BLK_W+1)'({1'b0, r_grid_row} + 17'd2)
                   * (ROW_W+BLK_W+1)'(br[BLK_W-1:0]);
        col_in   = col_end1 <= (SW_W+BLK_W+1)'(w);
        row_in   = row_end1 <= (ROW_W+BLK_W+1)'(h);
        cp_inc   = {1'b0, r_col_phase} + (PH_W+1)'(1);
        rp_inc   = {1'b0, r_row_phase} + (PH_W+1)'(1);
    end

    // Classified item
    always_comb begin
        o_item.depth = i_depth;
        o_item.col   = r_grid_col[COL_W-1:0];
        o_item.row   = r_grid_row;
        o_item.start = (r_row_phase == '0) && (r_col_phase == '0);
        o_item.acc   = col_in && row_in;
        o_item.emit  = col_in && row_in && (ROW_W'(rp_inc) >= br) && (SW_W'(cp_inc) >= bc);
        o_item.last  = (row_end2 > (ROW_W+BLK_W+1)'(h)) && (col_end2 > (SW_W+BLK_W+1)'(w));
        o_item.cnt   = CNT_W'(br[BLK_W-1:0]) * CNT_W'(bc[BLK_W-1:0]);
    end

    // Position counter update
    always_comb begin
        n_src_col   = r_src_col;
        n_src_row   = r_src_row;
        n_row_phase = r_row_phase;
        n_col_phase = r_col_phase;
        n_grid_row  = r_grid_row;
        n_grid_col  = r_grid_col;
        src_col_inc = {1'b0, r_src_col} + (SW_W+1)'(1);
        src_row_inc = {1'b0, r_src_row} + (ROW_W+1)'(1);
        if (i_push) begin
            n_src_col = src_col_inc[SW_W-1:0];
            if (col_in) begin
                if (SW_W'(cp_inc) >= bc) begin
                    n_col_phase = '0;
                    n_grid_col  = r_grid_col + SW_W'(1);
                end else begin
                    n_col_phase = cp_inc[PH_W-1:0];
                end
            end
            if (src_col_inc >= (SW_W+1)'(w)) begin
                n_src_col   = '0;
                n_col_phase = '0;
                n_grid_col  = '0;
                n_src_row   = src_row_inc[ROW_W-1:0];
                if (row_in) begin
                    if (ROW_W'(rp_inc) >= br) begin
                        n_row_phase = '0;
                        n_grid_row  = r_grid_row + ROW_W'(1);
                    end else begin
                        n_row_phase = rp_inc[PH_W-1:0];
                    end
                end
                if (src_row_inc >= (ROW_W+1)'(h)) begin
                    n_src_row   = '0;
                    n_row_phase = '0;
                    n_grid_row  = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col   <= '0;
            r_src_row   <= '0;
            r_row_phase <= '0;
            r_col_phase <= '0;
            r_grid_row  <= '0;
            r_grid_col  <= '0;
        end else begin
            r_src_col   <= n_src_col;
            r_src_row   <= n_src_row;
            r_row_phase <= n_row_phase;
            r_col_phase <= n_col_phase;
            r_grid_row  <= n_grid_row;
            r_grid_col  <= n_grid_col;
        end
    end
endmodule

FILE: hdl/bavg_queue.sv
// Two-entry item queue between front and back end. Depends on bavg_pkg.
module bavg_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bavg_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output bavg_pkg::t_item o_item
);
    import bavg_pkg::*;

    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wptr <= !r_wptr;
            if (do_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

FILE: hdl/bavg_back.sv
// Back end: band sum read-modify-write, serial divider for the block
// mean and the result register. Depends on bavg_pkg and bavg_ram.
module bavg_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_q_empty,
    input  bavg_pkg::t_item                      i_item,
    output logic                                 o_q_pop,
    output logic                                 o_empty,
    input  logic                                 i_pop,
    output logic signed [bavg_pkg::DEPTH_W-1:0]  o_mean_depth,
    output logic [bavg_pkg::ROW_W-1:0]           o_out_row,
    output logic [bavg_pkg::COL_W-1:0]           o_out_col,
    output logic                                 o_frame_last
);
    import bavg_pkg::*;

    t_state    r_state, n_state;
    t_back_ctl ctl;
    t_item     r_cur;

    logic [SUM_W-1:0]        ram_rdata;
    logic signed [SUM_W-1:0] sum;
    logic                    r_neg;
    logic [SUM_W-1:0]        r_quo;
    logic [CNT_W-1:0]        r_rem;
    logic [STEP_W-1:0]       r_step;
    logic [CNT_W:0]          rem_sh;
    logic                    fit;
    logic signed [SUM_W:0]   mean_w;
    logic                    r_out_valid;

    assign sum = r_cur.start ? SUM_W'(r_cur.depth)
                             : $signed(ram_rdata) + SUM_W'(r_cur.depth);

    // Band sum memory, one entry per column block
    bavg_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_sums (
        .i_clk   (i_clk),
        .i_we    (ctl.ram_we),
        .i_waddr (r_cur.col),
        .i_wdata (sum),
        .i_raddr (i_item.col),
        .o_rdata (ram_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (!i_q_empty) n_state = ST_ACC;
            ST_ACC:  n_state = r_cur.emit ? ST_DIV : ST_IDLE;
            ST_DIV:  if (r_step == STEP_W'(SUM_W - 1)) n_state = ST_DONE;
            ST_DONE: if (!r_out_valid || i_pop) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control strobes
    always_comb begin
        ctl = '0;
        case (r_state)
            ST_IDLE: ctl.q_pop = !i_q_empty;
            ST_ACC: begin
                ctl.ram_we   = r_cur.acc;
                ctl.div_load = r_cur.emit;
            end
            ST_DIV:  ;
            ST_DONE: ctl.out_load = !r_out_valid || i_pop;
            default: ;
        endcase
    end

    assign o_q_pop = ctl.q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // Restoring divide, one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign fit    = rem_sh >= (CNT_W+1)'(r_cur.cnt);

    always_ff @(posedge i_clk) begin
        if (ctl.q_pop) begin
            r_cur <= i_item;
        end
        if (ctl.div_load) begin
            r_neg  <= sum[SUM_W-1];
            r_quo  <= sum[SUM_W-1] ? SUM_W'(-sum) : sum;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_state == ST_DIV) begin
            r_rem  <= fit ? CNT_W'(rem_sh - (CNT_W+1)'(r_cur.cnt)) : rem_sh[CNT_W-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], fit};
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Sign of the mean; saturation is applied in the result register
    assign mean_w = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            o_mean_depth <= (mean_w > (SUM_W+1)'(32767)) ? DEPTH_W'(32767) :
                            (mean_w < -(SUM_W+1)'(32768)) ? DEPTH_W'(-32768) :
                            mean_w[DEPTH_W-1:0];
            o_out_row    <= r_cur.row;
            o_out_col    <= r_cur.col;
            o_frame_last <= r_cur.last;
        end
    end

    assign o_empty = !r_out_valid;
endmodule

FILE: hdl/block_average_downsampler_core.sv
// Block average downsampler, top level. Depends on bavg_pkg, bavg_front,
// bavg_queue, bavg_back (and bavg_ram inside the back end).
// A sample that closes no block occupies the back end for its idle state
// (band sum read) and accumulate state (write); one that closes a block
// also passes through the divide state, one quotient bit per cycle, and
// the done state. An unread result holds the back end and lets the queue
// fill. Synchronous active-low reset restores the register defaults and
// zeroes all counters; band sums need no clearing.
module block_average_downsampler_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bavg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [bavg_pkg::DEPTH_W-1:0] i_depth,
    output logic                                o_empty,
    input  logic                                i_pop,
    output logic signed [bavg_pkg::DEPTH_W-1:0] o_mean_depth,
    output logic [bavg_pkg::ROW_W-1:0]          o_out_row,
    output logic [bavg_pkg::COL_W-1:0]          o_out_col,
    output logic                                o_frame_last
);
    import bavg_pkg::*;

    t_item front_item, q_item;
    logic  q_empty, q_pop, accept;

    assign accept = i_push && !o_full;

    // Position tracking and classification
    bavg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_push     (accept),
        .i_depth    (i_depth),
        .o_item     (front_item)
    );

    // Decoupling queue
    bavg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (front_item),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    // Accumulate, divide, present result
    bavg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_item       (q_item),
        .o_q_pop      (q_pop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_mean_depth (o_mean_depth),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_last (o_frame_last)
    );
endmodule

FILE: test/tb_block_average_downsampler_core.sv
// Testbench for block_average_downsampler_core: streams whole raster frames
// under several register settings and checks every block average against
// its own predictor. Depends on bavg_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_block_average_downsampler_core;
    import bavg_pkg::*;

    localparam int  LIMIT_CYCLES = 4000000;
    localparam int  DRAIN_CYCLES = 1500;
    localparam int  HOLD_CYCLES  = 3000;

    typedef struct {
        logic signed [DEPTH_W-1:0] mean_depth;
        logic [ROW_W-1:0]          out_row;
        logic [COL_W-1:0]          out_col;
        logic                      frame_last;
    } t_avg;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]     i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                      i_push = 1'b0;
    logic                      o_full;
    logic signed [DEPTH_W-1:0] i_depth = '0;
    logic                      o_empty;
    logic                      i_pop = 1'b0;
    logic signed [DEPTH_W-1:0] o_mean_depth;
    logic [ROW_W-1:0]          o_out_row;
    logic [COL_W-1:0]          o_out_col;
    logic                      o_frame_last;

    block_average_downsampler_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_depth      (i_depth),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_mean_depth (o_mean_depth),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_frame_last (o_frame_last)
    );

    always #4 i_clk = ~i_clk;

    // Samples waiting to be offered, averages waiting to come out
    logic signed [DEPTH_W-1:0] pending_depths[$];
    t_avg                      expected_avgs[$];

    int  n_errors = 0;
    int  n_accepted = 0;
    int  cycle_cnt = 0;
    bit  took_item = 1'b0;
    bit  took_avg = 1'b0;
    bit  long_hold = 1'b0;
    bit  steady = 1'b0;
    int  push_gap = 0;
    int  pop_gap = 0;

    // Register mirror (raw values as written) and predictor state
    int unsigned reg_br = 4, reg_bc = 4, reg_w = 4096, reg_h = 4096;
    longint      band_sum[MAX_WIDTH];
    int unsigned pos_col, pos_row, ph_row, ph_col, blk_row, blk_col;

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Block-average predictor: advances the raster position for one sample
    task automatic predict_average(logic signed [DEPTH_W-1:0] d);
        int unsigned w, h, br, bc, grows, gcols;
        bit          col_in, row_in;
        longint      sum;
        t_avg        avg;
        w  = clamp_size(reg_w, MAX_WIDTH);
        h  = clamp_size(reg_h, MAX_HEIGHT);
        br = clamp_size(reg_br, MAX_BLOCK);
        bc = clamp_size(reg_bc, MAX_BLOCK);
        if (br > h) br = h;
        if (bc > w) bc = w;
        grows = h / br;
        gcols = w / bc;
        col_in = (blk_col < gcols) && (blk_col < MAX_WIDTH);
        row_in = blk_row < grows;
        if (col_in && row_in) begin
            if (ph_row == 0 && ph_col == 0) sum = longint'(d);
            else sum = band_sum[blk_col] + longint'(d);
            band_sum[blk_col] = sum;
            if (ph_row + 1 >= br && ph_col + 1 >= bc) begin
                sum = sum / longint'(br * bc);
                if (sum > 32767) sum = 32767;
                if (sum < -32768) sum = -32768;
                avg.mean_depth = sum[DEPTH_W-1:0];
                avg.out_row    = blk_row[ROW_W-1:0];
                avg.out_col    = blk_col[COL_W-1:0];
                avg.frame_last = (blk_row + 1 >= grows) && (blk_col + 1 >= gcols);
                expected_avgs.push_back(avg);
            end
        end
        pos_col++;
        if (col_in) begin
            ph_col++;
            if (ph_col >= bc) begin
                ph_col = 0;
                blk_col++;
            end
        end
        if (pos_col >= w) begin
            pos_col = 0;
            ph_col = 0;
            blk_col = 0;
            pos_row++;
            if (row_in) begin
                ph_row++;
                if (ph_row >= br) begin
                    ph_row = 0;
                    blk_row++;
                end
            end
            if (pos_row >= h) begin
                pos_row = 0; ph_row = 0; blk_row = 0;
            end
        end
    endtask

    // Input side: offer the next sample after a random gap
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_push && !took_item)) begin
            if (push_gap > 0) begin
                i_push <= 1'b0;
                push_gap <= push_gap - 1;
            end else if (pending_depths.size() > 0) begin
                i_depth <= pending_depths.pop_front();
                i_push <= 1'b1;
                if ($urandom_range(0, 199) == 0) steady = ~steady;
                push_gap <= steady ? 0 : $urandom_range(0, 3);
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // Output side: take results after a random stall, or not at all during the hold
    always @(negedge i_clk) begin
        if (long_hold || !i_rst_n) begin
            i_pop <= 1'b0;
        end else if (took_avg) begin
            pop_gap <= steady ? 0 : $urandom_range(0, 3);
            i_pop <= steady;
        end else if (pop_gap > 0) begin
            i_pop <= 1'b0;
            pop_gap <= pop_gap - 1;
        end else begin
            i_pop <= 1'b1;
        end
    end

    // Acceptance, prediction and checking at the rising edge
    always @(posedge i_clk) begin
        t_avg exp_avg;
        cycle_cnt++;
        took_item = i_rst_n && i_push && !o_full;
        took_avg = i_rst_n && i_pop && !o_empty;
        if (took_item) begin
            predict_average(i_depth);
            n_accepted++;
        end
        if (took_avg) begin
            if (expected_avgs.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected average: mean %0d row %0d col %0d last %0b",
                             o_mean_depth, o_out_row, o_out_col, o_frame_last);
            end else begin
                exp_avg = expected_avgs.pop_front();
                if (o_mean_depth !== exp_avg.mean_depth || o_out_row !== exp_avg.out_row ||
                    o_out_col !== exp_avg.out_col || o_frame_last !== exp_avg.frame_last) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp mean %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                                 exp_avg.mean_depth, exp_avg.out_row, exp_avg.out_col,
                                 exp_avg.frame_last, o_mean_depth, o_out_row, o_out_col,
                                 o_frame_last);
                end
            end
        end
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Back-pressure: stop taking results for a long stretch so the input stalls
    initial begin
        int held;
        held = 0;
        wait (n_accepted >= 100);
        @(negedge i_clk);
        long_hold = 1'b1;
        while (held < HOLD_CYCLES) begin
            @(negedge i_clk);
            held++;
        end
        long_hold = 1'b0;
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_BLOCK_ROWS: reg_br = value & 32'h7f;
            REG_BLOCK_COLS: reg_bc = value & 32'h7f;
            REG_SRC_WIDTH:  reg_w  = value & 32'h1fff;
            REG_SRC_HEIGHT: reg_h  = value & 32'hffff;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [DEPTH_W-1:0] rand_depth();
        case ($urandom_range(0, 9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Let every sample and average of the current setting go through
    task automatic drain();
        wait (pending_depths.size() == 0 && !i_push && expected_avgs.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Set the raster geometry and queue whole frames of random samples
    task automatic run_frames(int unsigned br, int unsigned bc, int unsigned w,
                              int unsigned h, int unsigned frames);
        int unsigned n;
        write_reg(REG_BLOCK_ROWS, br);
        write_reg(REG_BLOCK_COLS, bc);
        write_reg(REG_SRC_WIDTH, w);
        write_reg(REG_SRC_HEIGHT, h);
        n = frames * clamp_size(reg_w, MAX_WIDTH) * clamp_size(reg_h, MAX_HEIGHT);
        repeat (n) pending_depths.push_back(rand_depth());
        drain();
    endtask

    initial begin
        logic signed [DEPTH_W-1:0] directed[20];
        int unsigned rnd_items, w, h, n_frames;
        directed = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0001,
                     16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh1234,
                     16'shffff, 16'sh0000, 16'sh0003, 16'sh0001, 16'sh5555,
                     16'sh0000, 16'shfffe, 16'shfffc, 16'sh7ffe, 16'shaaaa};
        rnd_items = 0;
        pos_col = 0; pos_row = 0; ph_row = 0; ph_col = 0; blk_row = 0; blk_col = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 2x2 blocks over a 5x4 raster, trailing column dropped,
        // full-scale and negative sums that truncate toward zero
        write_reg(REG_BLOCK_ROWS, 2);
        write_reg(REG_BLOCK_COLS, 2);
        write_reg(REG_SRC_WIDTH, 5);
        write_reg(REG_SRC_HEIGHT, 4);
        foreach (directed[i]) pending_depths.push_back(directed[i]);
        drain();

        run_frames(0, 0, 3, 2, 2);        // zero block size acts as 1
        run_frames(9, 9, 3, 2, 2);        // block clipped to the source
        run_frames(0, 0, 0, 0, 3);        // zero source size acts as 1
        run_frames(127, 100, 1, 66, 1);   // oversized block rows saturate
        run_frames(100, 127, 66, 1, 1);   // oversized block columns saturate
        run_frames(64, 1, 1, 130, 1);     // trailing rows dropped

        // Random geometries, mostly small
        while (rnd_items < 1700) begin
            w = $urandom_range(1, 40);
            h = $urandom_range(1, 20);
            n_frames = $urandom_range(1, 3);
            rnd_items += w * h * n_frames;
            run_frames($urandom_range(0, 9), $urandom_range(0, 9), w, h, n_frames);
        end

        if (n_errors == 0 && expected_avgs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/bavg_pkg.sv
hdl/bavg_ram.sv
hdl/bavg_front.sv
hdl/bavg_queue.sv
hdl/bavg_back.sv
hdl/block_average_downsampler_core.sv
test/tb_block_average_downsampler_core.sv
